@@ hdl/bpfm_pkg.sv @@
// bpfm_pkg: shared types and constants of the byte pattern first match block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpfm_pkg;

   localparam int PAT_BYTES = 32;
   localparam int PAT_IDX_W = 5;
   localparam int PAT_WORDS = 4;
   // holds a pattern length or a byte place up to 127
   localparam int IDX_W     = 7;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_LO     = 3'd1,
      CSR_PATTERN_MID_LO = 3'd2,
      CSR_PATTERN_MID_HI = 3'd3,
      CSR_PATTERN_HI     = 3'd4,
      CSR_BASE_ADDRESS   = 3'd5
   } csr_index_type;

   typedef logic [7:0] pat_bytes_type [PAT_BYTES];

   typedef struct packed {
      logic       vld;
      logic [7:0] data;
   } tap_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_address;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/bpfm_if.sv @@
// bpfm channel interfaces: text byte items, result items, register writes
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bpfm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;
   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface bpfm_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_address;
   modport source (output valid, output found, output match_address, input ready);
   modport sink (input valid, input found, input match_address, output ready);
endinterface

interface bpfm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/bpfm_cell.sv @@
// bpfm_cell: one window byte with its fill bit and its pattern compare
// depends on bpfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpfm_cell #(
   parameter int IDX   = 0,
   parameter int LEN_W = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     shift,
   input  wire logic                     flush,
   input  wire logic [LEN_W-1:0]         eff_len,
   input  wire bpfm_pkg::pat_bytes_type  pat,
   input  wire bpfm_pkg::tap_type        tap_prev,
   output bpfm_pkg::tap_type             tap_out,
   output logic                          hit
);
   import bpfm_pkg::*;

   localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(IDX);

   logic             vld_ff;
   logic [7:0]       data_ff;
   logic [IDX_W-1:0] len_w;
   logic [IDX_W-1:0] pat_pos;
   logic             active;
   logic [7:0]       pat_byte;

   always_comb begin
      len_w    = IDX_W'(eff_len);
      active   = CELL_IDX < len_w;
      pat_pos  = len_w - CELL_IDX - IDX_W'(1);
      pat_byte = (pat_pos < IDX_W'(PAT_BYTES)) ? pat[pat_pos[PAT_IDX_W-1:0]] : 8'h00;
      hit      = !active || (tap_prev.vld && (tap_prev.data == pat_byte));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (shift) begin
         vld_ff <= tap_prev.vld && !flush;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= tap_prev.data;
      end
   end

   assign tap_out = '{vld: vld_ff, data: data_ff};

endmodule

`default_nettype wire

@@ hdl/byte_pattern_first_match.sv @@
// byte_pattern_first_match: leftmost search of a byte pattern in a text stream
// depends on bpfm_pkg, bpfm_if.sv interfaces and bpfm_cell
//
//   channel   dir  handshake     carries
//   req_ch    in   valid/ready   text_byte, last_byte
//   rsp_ch    out  valid/ready   found, match_address
//   csr_ch    in   valid/ready   index, data (register write)
//
// one text byte per cycle while req_ch.ready is high; the row of cells compares the whole window at once
// a result is registered with its last byte into a two-entry output queue
// req_ch.ready falls only while both output entries are full
// csr_ch.ready is always high
// synchronous reset clears fill bits, counters and queue; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_first_match #(
   parameter int PATTERN_MAX = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   bpfm_req_if.sink   req_ch,
   bpfm_rsp_if.source rsp_ch,
   bpfm_csr_if.sink   csr_ch
);
   import bpfm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [5:0]          len_ff;
   logic [63:0]         pat_word_ff [PAT_WORDS];
   logic [31:0]         base_ff;
   pat_bytes_type       pat;
   logic [LEN_W-1:0]    eff_len;

   // search state
   logic [31:0]         byte_index_ff;
   logic                seen_ff;
   logic [31:0]         offset_ff;

   // output queue
   logic                main_vld_ff;
   rsp_type             main_ff;
   logic                spare_vld_ff;
   rsp_type             spare_ff;

   tap_type             chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hits;

   logic                accept;
   logic                flush;
   logic                pop;
   logic                match_now;
   logic                seen_in;
   logic [31:0]         offset_in;
   rsp_type             result_in;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 6'd1;
         base_ff <= '0;
         for (int w = 0; w < PAT_WORDS; w++) begin
            pat_word_ff[w] <= '0;
         end
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_PATTERN_LENGTH: len_ff <= csr_ch.data[5:0];
            CSR_PATTERN_LO:     pat_word_ff[0] <= csr_ch.data;
            CSR_PATTERN_MID_LO: pat_word_ff[1] <= csr_ch.data;
            CSR_PATTERN_MID_HI: pat_word_ff[2] <= csr_ch.data;
            CSR_PATTERN_HI:     pat_word_ff[3] <= csr_ch.data;
            CSR_BASE_ADDRESS:   base_ff <= csr_ch.data[31:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   always_comb begin
      for (int k = 0; k < PAT_BYTES; k++) begin
         pat[k] = pat_word_ff[k / 8][(k % 8) * 8 +: 8];
      end
      if (len_ff == 6'd0) begin
         eff_len = LEN_W'(1);
      end else if (IDX_W'(len_ff) > IDX_W'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = LEN_W'(len_ff);
      end
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign flush    = req_ch.last_byte;
   assign chain[0] = '{vld: 1'b1, data: req_ch.text_byte};

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      if (i < PATTERN_MAX - 1) begin : g_mid
         bpfm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .flush    (flush),
            .eff_len  (eff_len),
            .pat      (pat),
            .tap_prev (chain[i]),
            .tap_out  (chain[i+1]),
            .hit      (hits[i])
         );
      end else begin : g_end
         bpfm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .flush    (flush),
            .eff_len  (eff_len),
            .pat      (pat),
            .tap_prev (chain[i]),
            .tap_out  (),
            .hit      (hits[i])
         );
      end
   end

   always_comb begin
      match_now = &hits;
      seen_in   = seen_ff;
      offset_in = offset_ff;
      if (!seen_ff && match_now) begin
         seen_in   = 1'b1;
         offset_in = byte_index_ff - (32'(eff_len) - 32'd1);
      end
      result_in.found         = seen_in;
      result_in.match_address = seen_in ? (base_ff + offset_in) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         seen_ff       <= 1'b0;
         offset_ff     <= '0;
      end else if (accept) begin
         if (flush) begin
            byte_index_ff <= '0;
            seen_ff       <= 1'b0;
            offset_ff     <= '0;
         end else begin
            byte_index_ff <= byte_index_ff + 32'd1;
            seen_ff       <= seen_in;
            offset_ff     <= offset_in;
         end
      end
   end

   // output queue
   assign pop          = main_vld_ff && rsp_ch.ready;
   assign req_ch.ready = !spare_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff  <= 1'b0;
         spare_vld_ff <= 1'b0;
      end else if (pop && spare_vld_ff) begin
         main_vld_ff  <= 1'b1;
         spare_vld_ff <= 1'b0;
      end else if (pop || !main_vld_ff) begin
         main_vld_ff  <= accept && flush;
      end else if (accept && flush) begin
         spare_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && spare_vld_ff) begin
         main_ff <= spare_ff;
      end else if (pop || !main_vld_ff) begin
         main_ff <= result_in;
      end else if (accept && flush) begin
         spare_ff <= result_in;
      end
   end

   assign rsp_ch.valid         = main_vld_ff;
   assign rsp_ch.found         = main_ff.found;
   assign rsp_ch.match_address = main_ff.match_address;

`ifndef SYNTHESIS
   a_spare_needs_main: assert property (@(posedge clock) disable iff (reset)
      spare_vld_ff |-> main_vld_ff)
      else $error("spare entry held while main entry empty");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && flush |=> byte_index_ff == 32'd0 && !seen_ff)
      else $error("search state not restarted after last item");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      main_vld_ff && !main_ff.found |-> main_ff.match_address == 32'd0)
      else $error("address nonzero on a not found result");

   a_first_match_kept: assert property (@(posedge clock) disable iff (reset)
      accept && !flush && seen_ff |=> seen_ff && $stable(offset_ff))
      else $error("latched first match changed");
`endif

endmodule

`default_nettype wire

@@ tb/sv/byte_pattern_first_match_tb.sv @@
// byte_pattern_first_match_tb: streams text buffers through the pattern search block,
// predicts the leftmost match of each buffer, or takes it from a typed directed row, and checks every result item
// depends on bpfm_pkg, the bpfm_if.sv interfaces and byte_pattern_first_match
`timescale 1ns / 1ps

module byte_pattern_first_match_tb;
   import bpfm_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_ITEMS  = 450;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_TEXT,
      ROW_TEXT_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [63:0]          data;
      logic [7:0]           text;
      logic                 fin;
      logic                 found;
      logic [31:0]          addr;
   } row_type;

   row_type directed_rows [31] = '{
      '{ROW_TEXT_TYPED, CSR_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, 1'b1, 32'h0},
      '{ROW_TEXT_TYPED, CSR_PATTERN_LENGTH, 64'h0, 8'hff, 1'b1, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LO, 64'h41, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_BASE_ADDRESS, 64'hffff_fffe, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_SPARE_A, '1, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h42, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT_TYPED, CSR_PATTERN_LENGTH, 64'h0, 8'h41, 1'b1, 1'b1, 32'hffff_ffff},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'h3, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LO, 64'h63_6261, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_BASE_ADDRESS, 64'h1000, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h61, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT_TYPED, CSR_PATTERN_LENGTH, 64'h0, 8'h62, 1'b1, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h61, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h62, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h63, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h61, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h62, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT_TYPED, CSR_PATTERN_LENGTH, 64'h0, 8'h63, 1'b1, 1'b1, 32'h1000},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'h2, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LO, 64'h80_01, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_SPARE_B, 64'h0, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h01, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h01, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'h80, 1'b1, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'h3f, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_MID_LO, '1, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_MID_HI, 64'h0, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_HI, '1, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_PATTERN_LO, '1, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_TEXT, CSR_PATTERN_LENGTH, 64'h0, 8'hff, 1'b1, 1'b0, 32'h0}
   };

   logic clock;
   logic reset;

   bpfm_req_if req_ch ();
   bpfm_rsp_if rsp_ch ();
   bpfm_csr_if csr_ch ();

   byte_pattern_first_match #(
      .PATTERN_MAX(PAT_BYTES)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // predictor copy of registers and search state
   logic [5:0]  cfg_len;
   logic [63:0] cfg_pat [PAT_WORDS];
   logic [31:0] cfg_base;
   logic [7:0]  win [PAT_BYTES];
   int unsigned win_fill;
   logic [31:0] buf_pos;
   logic        hit_seen;
   logic [31:0] hit_offset;

   rsp_type pending_results [$];
   int      mismatches;
   int      quiet_cycles;
   int      text_items_sent;
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      typed_pending;
   rsp_type typed_rsp;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void restart_search();
      buf_pos    = '0;
      hit_seen   = 1'b0;
      hit_offset = '0;
      win_fill   = 0;
   endfunction

   function automatic int unsigned active_length();
      int unsigned n;
      n = cfg_len;
      if (n == 0) n = 1;
      if (n > PAT_BYTES) n = PAT_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] pattern_at(input int unsigned k);
      if (k >= PAT_BYTES) return 8'h00;
      return cfg_pat[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic void apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      case (idx)
         CSR_PATTERN_LENGTH: cfg_len    = data[5:0];
         CSR_PATTERN_LO:     cfg_pat[0] = data;
         CSR_PATTERN_MID_LO: cfg_pat[1] = data;
         CSR_PATTERN_MID_HI: cfg_pat[2] = data;
         CSR_PATTERN_HI:     cfg_pat[3] = data;
         CSR_BASE_ADDRESS:   cfg_base   = data[31:0];
         default: ;
      endcase
   endfunction

   // shifts one text byte into the window; returns 1 with the result on the last byte
   function automatic bit scan_text_byte(input logic [7:0] b, input logic fin,
                                         output rsp_type r);
      int unsigned n;
      bit          ok;
      r = '0;
      n = active_length();
      for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = b;
      if (win_fill < PAT_BYTES) win_fill++;
      if (!hit_seen && win_fill >= n) begin
         ok = 1'b1;
         for (int k = 0; k < n; k++) begin
            if (win[n - 1 - k] != pattern_at(k)) ok = 1'b0;
         end
         if (ok) begin
            hit_seen   = 1'b1;
            hit_offset = buf_pos - (n - 1);
         end
      end
      buf_pos = buf_pos + 1;
      if (!fin) return 1'b0;
      r.found         = hit_seen;
      r.match_address = hit_seen ? cfg_base + hit_offset : '0;
      restart_search();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(negedge clock) begin : monitor
      rsp_type predicted;
      rsp_type oldest;
      bit      busy;
      if (!reset) begin
         busy = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            apply_write(csr_ch.index, csr_ch.data);
            busy = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            if (scan_text_byte(req_ch.text_byte, req_ch.last_byte, predicted)) begin
               pending_results.push_back(typed_pending ? typed_rsp : predicted);
            end
            busy = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            busy = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_ch.found !== oldest.found)
                  report_mismatch($sformatf("found %0b, expected %0b",
                                            rsp_ch.found, oldest.found));
               if (rsp_ch.match_address !== oldest.match_address)
                  report_mismatch($sformatf("match_address %h, expected %h",
                                            rsp_ch.match_address, oldest.match_address));
            end
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic send_text(input logic [7:0] b, input logic fin, input bit typed,
                            input rsp_type exp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      typed_pending = typed;
      typed_rsp     = exp;
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= b;
      req_ch.last_byte <= fin;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      text_items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(negedge clock); while (!csr_ch.ready);
      @(posedge clock);
   endtask

   // holds the sender until every result is back and the block has settled
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_word();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic new_settings();
      int unsigned r;
      logic [5:0]  len;
      logic [31:0] base;
      wait_drained();
      r = $urandom_range(99);
      if (r < 55) len = 6'($urandom_range(4, 1));
      else if (r < 80) len = 6'($urandom_range(12, 5));
      else if (r < 93) len = 6'($urandom_range(32, 13));
      else if (r < 96) len = 6'd0;
      else len = 6'($urandom_range(63, 33));
      r = $urandom_range(9);
      if (r == 0) base = '0;
      else if (r == 1) base = '1;
      else if (r == 2) base = 32'hffff_fff0 + $urandom_range(15);
      else base = $urandom;
      write_csr(CSR_PATTERN_LENGTH, {58'h0, len});
      write_csr(CSR_PATTERN_LO, pick_word());
      write_csr(CSR_PATTERN_MID_LO, pick_word());
      write_csr(CSR_PATTERN_MID_HI, pick_word());
      write_csr(CSR_PATTERN_HI, pick_word());
      write_csr(CSR_BASE_ADDRESS, {$urandom, base});
      if ($urandom_range(4) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_buffer();
      logic [7:0]  text [$];
      int unsigned n;
      int unsigned len;
      int unsigned pos;
      int unsigned kind;
      len  = active_length();
      kind = $urandom_range(99);
      if (kind < 15) begin
         // noise
         n = $urandom_range(12, 1);
         repeat (n) text.push_back(8'($urandom));
      end else if (kind < 25 && len > 1) begin
         // shorter than the pattern, mostly its prefix
         n = $urandom_range(len - 1, 1);
         for (int i = 0; i < n; i++)
            text.push_back($urandom_range(3) == 0 ? 8'($urandom) : pattern_at(i));
      end else begin
         n = len + $urandom_range(10);
         for (int i = 0; i < n; i++)
            text.push_back($urandom_range(1) ? pattern_at($urandom_range(len - 1))
                                             : 8'($urandom));
         if ($urandom_range(4) != 0) begin
            pos = $urandom_range(n - len);
            for (int k = 0; k < len; k++) text[pos + k] = pattern_at(k);
         end
         if ($urandom_range(2) == 0) begin
            pos = $urandom_range(n - len);
            for (int k = 0; k < len; k++) text[pos + k] = pattern_at(k);
         end
      end
      for (int i = 0; i < n; i++) send_text(text[i], i == n - 1, 1'b0, '0);
   endtask

   initial begin : stimulus
      row_type      row;
      row_kind_type prev_kind;
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = '0;
      req_ch.last_byte = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      rsp_ch.ready     = 1'b0;
      mismatches       = 0;
      quiet_cycles     = 0;
      text_items_sent  = 0;
      typed_pending    = 1'b0;
      typed_rsp        = '0;
      send_idle_pct    = 16;
      recv_idle_pct    = 84;
      cfg_len          = 6'd1;
      cfg_base         = '0;
      for (int i = 0; i < PAT_WORDS; i++) cfg_pat[i] = '0;
      for (int i = 0; i < PAT_BYTES; i++) win[i] = '0;
      restart_search();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      prev_kind = ROW_TEXT;
      for (int i = 0; i < $size(directed_rows); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            if (prev_kind != ROW_WRITE) wait_drained();
            write_csr(row.idx, row.data);
         end else begin
            if (prev_kind == ROW_WRITE) csr_ch.valid <= 1'b0;
            send_text(row.text, row.fin, row.kind == ROW_TEXT_TYPED,
                      rsp_type'{row.found, row.addr});
         end
         prev_kind = row.kind;
      end

      text_items_sent = 0;
      while (text_items_sent < RANDOM_ITEMS) begin
         if (text_items_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 84;
         end else if (text_items_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 84;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         new_settings();
         repeat ($urandom_range(5, 2)) begin
            run_buffer();
            if ($urandom_range(9) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/bpfm_pkg.sv
hdl/bpfm_if.sv
hdl/bpfm_cell.sv
hdl/byte_pattern_first_match.sv
tb/sv/byte_pattern_first_match_tb.sv
